### rtl/core/speed_pi_controller_antiwindup_core_macros.svh
// Assertion macros for the speed PI controller core.
`ifndef SPEED_PI_CONTROLLER_ANTIWINDUP_CORE_MACROS_SVH
`define SPEED_PI_CONTROLLER_ANTIWINDUP_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPDPI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPDPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/spdpi_pkg.sv
// Package: register map, reset values and limits of the speed PI controller.
package spdpi_pkg;

  typedef enum logic [1:0] {
    REG_PROP_GAIN    = 2'd0,
    REG_INTEG_GAIN   = 2'd1,
    REG_TARGET_LIMIT = 2'd2
  } reg_idx_e;

  localparam int GAIN_W  = 12;
  localparam int LIMIT_W = 15;
  localparam int INTEG_W = 14;
  localparam int DRIVE_W = 11;
  localparam int SPEED_W = 16;

  localparam int INTEG_MAX   = 8000;
  localparam int OUT_MAX     = 1000;
  localparam int STILL_SPEED = 5;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 12'd512;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = 12'd26;
  localparam logic [LIMIT_W-1:0] TARGET_LIMIT_RST = 15'd300;

endpackage

### rtl/core/speed_pi_controller_antiwindup_core.sv
// Speed PI controller with target clamp and integrator clamp (anti-windup).
// An accepted input beat passes through the input register, then the result
// register; throughput one beat per cycle while the result channel is not stalled.
// The integrator is updated in the single cycle that moves an item into the
// result register, so each item sees the integrator left by the one before.
// Reset clears the integrator and valids and loads the default gains and limit.
`include "speed_pi_controller_antiwindup_core_macros.svh"

module speed_pi_controller_antiwindup_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [15:0] target_command_i,
  input  logic signed [15:0] measured_speed_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [10:0] drive_value_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------- config
  logic [11:0] prop_gain_q;
  logic [11:0] integ_gain_q;
  logic [14:0] target_limit_q;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q    <= spdpi_pkg::PROP_GAIN_RST;
      integ_gain_q   <= spdpi_pkg::INTEG_GAIN_RST;
      target_limit_q <= spdpi_pkg::TARGET_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        spdpi_pkg::REG_PROP_GAIN:    prop_gain_q    <= pwdata[11:0];
        spdpi_pkg::REG_INTEG_GAIN:   integ_gain_q   <= pwdata[11:0];
        spdpi_pkg::REG_TARGET_LIMIT: target_limit_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      spdpi_pkg::REG_PROP_GAIN:    prdata = {20'd0, prop_gain_q};
      spdpi_pkg::REG_INTEG_GAIN:   prdata = {20'd0, integ_gain_q};
      spdpi_pkg::REG_TARGET_LIMIT: prdata = {17'd0, target_limit_q};
      default:                     prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------- input stage
  logic               in_vld_q;
  logic signed [15:0] target_q;
  logic signed [15:0] meas_q;
  logic               adv;
  logic               in_take;

  // advance into the result register when it is empty or being drained
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = in_vld_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv || !in_vld_q) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      target_q <= target_command_i;
      meas_q   <= measured_speed_i;
    end
  end

  // ------------------------------------------------------------- datapath
  logic signed [16:0] tgt_ext;
  logic signed [16:0] lim_pos;
  logic signed [16:0] lim_neg;
  logic signed [16:0] tgt_clamp;
  logic signed [16:0] cur;
  logic signed [16:0] err;
  logic signed [17:0] acc_sum;
  logic signed [13:0] acc_clamp;
  logic               still;
  logic signed [13:0] integ_q;
  logic signed [13:0] integ_d;
  logic signed [29:0] prod_p;
  logic signed [26:0] prod_i;
  logic signed [30:0] pid_sum;
  logic signed [22:0] pid_shr;
  logic signed [10:0] drive_d;
  logic signed [10:0] drive_q;
  logic               out_vld_q;

  always_comb begin
    tgt_ext = {target_q[15], target_q};
    lim_pos = $signed({2'b00, target_limit_q});
    lim_neg = -lim_pos;
    tgt_clamp = tgt_ext;
    if (target_limit_q != 15'd0) begin
      if (tgt_ext > lim_pos) begin
        tgt_clamp = lim_pos;
      end else if (tgt_ext < lim_neg) begin
        tgt_clamp = lim_neg;
      end
    end

    // current speed is the negated measurement; full width keeps +32768
    cur = -$signed({meas_q[15], meas_q});
    err = tgt_clamp - cur;

    acc_sum = {{4{integ_q[13]}}, integ_q} + {err[16], err};
    if (acc_sum > spdpi_pkg::INTEG_MAX) begin
      acc_clamp = 14'(spdpi_pkg::INTEG_MAX);
    end else if (acc_sum < -spdpi_pkg::INTEG_MAX) begin
      acc_clamp = 14'(-spdpi_pkg::INTEG_MAX);
    end else begin
      acc_clamp = acc_sum[13:0];
    end

    // drop the integrator at standstill with zero target
    still = (tgt_clamp == 17'sd0) && (cur < spdpi_pkg::STILL_SPEED)
            && (cur > -spdpi_pkg::STILL_SPEED);
    integ_d = still ? 14'sd0 : acc_clamp;

    prod_p  = 30'($signed({1'b0, prop_gain_q})) * 30'(err);
    prod_i  = 27'($signed({1'b0, integ_gain_q})) * 27'(integ_d);
    pid_sum = {prod_p[29], prod_p} + {{4{prod_i[26]}}, prod_i};
    pid_shr = pid_sum[30:8];   // arithmetic shift by 8 rounds towards minus infinity

    if (pid_shr > spdpi_pkg::OUT_MAX) begin
      drive_d = 11'(spdpi_pkg::OUT_MAX);
    end else if (pid_shr < -spdpi_pkg::OUT_MAX) begin
      drive_d = 11'(-spdpi_pkg::OUT_MAX);
    end else begin
      drive_d = pid_shr[10:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q   <= 14'sd0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
      if (in_vld_q) begin
        integ_q <= integ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_vld_q) begin
      drive_q <= drive_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign drive_value_o = drive_q;

  // ----------------------------------------------------------- assertions
  `SPDPI_ASSERT_NOW(a_integ_range, clk_i, rst_ni, 1'b1, (integ_q <= 14'sd8000) && (integ_q >= -14'sd8000), "integrator outside clamp")
  `SPDPI_ASSERT_NOW(a_drive_range, clk_i, rst_ni, out_vld_q, (drive_q <= 11'sd1000) && (drive_q >= -11'sd1000), "drive value outside clamp")
  `SPDPI_ASSERT_NEXT(a_integ_hold, clk_i, rst_ni, !(adv && in_vld_q), $stable(integ_q), "integrator moved without an item")
  `SPDPI_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o, out_vld_q && out_stall_i && in_vld_q, "input stalled without a full pipe")

endmodule
